// ----- design/apps_pkg.sv -----
// shared types and constants of the adaptive page policy scheduler
`default_nettype none

package apps_pkg;

   // bank index space and row field
   localparam int NUM_BANK_IDX = 16;
   localparam int BANK_W       = 4;
   localparam int ROW_FIELD_W  = 16;
   localparam int OCC_W        = 7;
   localparam int THRESH_W     = 4;
   localparam int COUNT_W      = 4;

   // policy counter limits
   localparam logic [COUNT_W-1:0] COUNT_TOP   = 4'd15;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd8;

   // configuration reset values
   localparam logic [OCC_W-1:0]    DRAIN_HIGH_RESET   = 7'd40;
   localparam logic [OCC_W-1:0]    DRAIN_LOW_RESET    = 7'd20;
   localparam logic [THRESH_W-1:0] CLOSED_THRESH_RESET = 4'd11;
   localparam logic [THRESH_W-1:0] OPEN_THRESH_RESET   = 4'd6;

   // channel widths
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DRAIN_HIGH    = 2'd0,
      CSR_DRAIN_LOW     = 2'd1,
      CSR_CLOSED_THRESH = 2'd2,
      CSR_OPEN_THRESH   = 2'd3
   } csr_index_type;

   // command of the oldest issuable request
   typedef enum logic [1:0] {
      OP_COLUMN    = 2'd0,
      OP_ACTIVATE  = 2'd1,
      OP_PRECHARGE = 2'd2,
      OP_OTHER     = 2'd3
   } cmd_op_type;

   // input item, last member in the lowest bits
   typedef struct packed {
      logic [3:0]              pad;
      logic [15:0]             precharge_allowed_mask;
      logic [ROW_FIELD_W-1:0]  read_row;
      logic [BANK_W-1:0]       read_bank_index;
      cmd_op_type              read_next_op;
      logic                    read_ready;
      logic [ROW_FIELD_W-1:0]  write_row;
      logic [BANK_W-1:0]       write_bank_index;
      cmd_op_type              write_next_op;
      logic                    write_ready;
      logic [OCC_W-1:0]        reads_waiting;
      logic [OCC_W-1:0]        writes_waiting;
   } req_item_type;

   // result item, last member in the lowest bits
   typedef struct packed {
      logic [2:0]         pad;
      logic [COUNT_W-1:0] policy_count;
      logic               draining;
      logic               closed_mode;
      logic [BANK_W-1:0]  precharge_bank;
      logic               issue_precharge;
      logic               issue_is_write;
      logic               issue_request;
   } rsp_item_type;

   // outcome of the precharge candidate search
   typedef struct packed {
      logic              found;
      logic [BANK_W-1:0] bank;
   } pre_pick_type;

endpackage

`default_nettype wire

// ----- design/apps_pre_pick.sv -----
// lowest-index search over precharge candidate banks
`default_nettype none

module apps_pre_pick
   import apps_pkg::*;
#(
   parameter int SCAN_COUNT = 16
) (
   input  wire logic [NUM_BANK_IDX-1:0] cand,
   output pre_pick_type                 pick
);

   // walk from the top so the lowest candidate wins
   always_comb begin
      pick = '0;
      for (int i = NUM_BANK_IDX - 1; i >= 0; i--) begin
         if (cand[i] && (i < SCAN_COUNT)) begin
            pick.found = 1'b1;
            pick.bank  = BANK_W'(i);
         end
      end
   end

endmodule

`default_nettype wire

// ----- design/adaptive_page_policy_scheduler.sv -----
// top level of the adaptive open/closed page policy command scheduler
`default_nettype none

// One scheduling decision per item, one item per clock while the result
// stream is not stalled. An accepted item is held in an input register;
// from there the drain flag, page policy, per-bank row tracking and the
// precharge search are evaluated in one pass and the decision lands in the
// result register once that is free, while the next item may already be
// taken. The per-bank state feeds back directly from one item to the next,
// which allows one item per clock. A stalled result holds the input stage
// once it is full. Configuration writes take effect on the next edge.
module adaptive_page_policy_scheduler
   import apps_pkg::*;
#(
   parameter int RANKS    = 2,
   parameter int BANKS    = 8,
   parameter int ROW_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // configuration write port
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   // request stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // tdata from bit 0: writes_waiting, reads_waiting, write_ready, write_next_op,
   // write_bank_index, write_row, read_ready, read_next_op, read_bank_index,
   // read_row, precharge_allowed_mask, zero fill
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // result stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // tdata from bit 0: issue_request, issue_is_write, issue_precharge,
   // precharge_bank, closed_mode, draining, policy_count, zero fill
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   localparam int RowKeep  = (ROW_BITS < ROW_FIELD_W) ? ROW_BITS : ROW_FIELD_W;
   localparam int NumScan  = (RANKS * BANKS > NUM_BANK_IDX) ? NUM_BANK_IDX : RANKS * BANKS;

   // configuration registers
   logic [OCC_W-1:0]    drain_high_ff,   drain_high_in;
   logic [OCC_W-1:0]    drain_low_ff,    drain_low_in;
   logic [THRESH_W-1:0] closed_thresh_ff, closed_thresh_in;
   logic [THRESH_W-1:0] open_thresh_ff,  open_thresh_in;

   // pipeline control and payload
   logic         s0_valid_ff, s0_valid_in;
   req_item_type s0_item_ff,  s0_item_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff,  rsp_item_in;
   logic         advance;

   // scheduler state
   logic                     drain_flag_ff,  drain_flag_in;
   logic [COUNT_W-1:0]       policy_count_ff, policy_count_in;
   logic                     policy_closed_ff, policy_closed_in;
   logic [NUM_BANK_IDX-1:0]  row_known_ff,   row_known_in;
   logic [NUM_BANK_IDX-1:0]  recent_ff,      recent_in;
   logic [RowKeep-1:0]       last_row_ff [NUM_BANK_IDX];

   // decision signals
   logic                     drain_now;
   logic                     closed_now;
   logic                     issued;
   cmd_op_type               sel_op;
   logic [BANK_W-1:0]        sel_bank;
   logic [RowKeep-1:0]       sel_row;
   logic                     row_hit;
   logic                     row_we;
   logic [COUNT_W-1:0]       count_now;
   logic [NUM_BANK_IDX-1:0]  recent_mid;
   logic [NUM_BANK_IDX-1:0]  pre_cand;
   pre_pick_type             pick;
   logic                     do_pre;

   // configuration writes
   always_comb begin
      drain_high_in    = drain_high_ff;
      drain_low_in     = drain_low_ff;
      closed_thresh_in = closed_thresh_ff;
      open_thresh_in   = open_thresh_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_DRAIN_HIGH:    drain_high_in    = csr_wdata;
            CSR_DRAIN_LOW:     drain_low_in     = csr_wdata;
            CSR_CLOSED_THRESH: closed_thresh_in = csr_wdata[THRESH_W-1:0];
            CSR_OPEN_THRESH:   open_thresh_in   = csr_wdata[THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   // handshake and stage movement
   assign advance    = s0_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s0_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_item_ff;

   always_comb begin
      s0_item_in  = s0_item_ff;
      s0_valid_in = s0_valid_ff;
      if (req_tvalid && req_tready) begin
         s0_item_in  = req_item_type'(req_tdata);
         s0_valid_in = 1'b1;
      end else if (advance) begin
         s0_valid_in = 1'b0;
      end
      rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   // drain hysteresis and page policy selection
   always_comb begin
      drain_now = (drain_flag_ff && (s0_item_ff.writes_waiting > drain_low_ff))
                  || (s0_item_ff.writes_waiting > drain_high_ff)
                  || (s0_item_ff.reads_waiting == '0);
      closed_now = policy_closed_ff;
      if (policy_count_ff > closed_thresh_ff) closed_now = 1'b1;
      if (policy_count_ff < open_thresh_ff)   closed_now = 1'b0;
   end

   // pick the side that issues and its request
   always_comb begin
      if (drain_now) begin
         issued   = s0_item_ff.write_ready;
         sel_op   = s0_item_ff.write_next_op;
         sel_bank = s0_item_ff.write_bank_index;
         sel_row  = s0_item_ff.write_row[RowKeep-1:0];
      end else begin
         issued   = s0_item_ff.read_ready;
         sel_op   = s0_item_ff.read_next_op;
         sel_bank = s0_item_ff.read_bank_index;
         sel_row  = s0_item_ff.read_row[RowKeep-1:0];
      end
      row_hit = row_known_ff[sel_bank] && (last_row_ff[sel_bank] == sel_row);
   end

   // per-bank tracking and policy counter update
   always_comb begin
      count_now  = policy_count_ff;
      recent_mid = recent_ff;
      row_we     = 1'b0;
      if (issued && (sel_op == OP_COLUMN)) begin
         if (closed_now) begin
            recent_mid[sel_bank] = 1'b1;
            if (row_hit) begin
               if (policy_count_ff != '0) count_now = policy_count_ff - 1'b1;
            end else begin
               row_we = 1'b1;
            end
         end else if (!row_hit) begin
            row_we = 1'b1;
            if (policy_count_ff != COUNT_TOP) count_now = policy_count_ff + 1'b1;
         end
      end else if (issued && closed_now &&
                   ((sel_op == OP_ACTIVATE) || (sel_op == OP_PRECHARGE))) begin
         recent_mid[sel_bank] = 1'b0;
      end
   end

   // preemptive precharge candidates
   assign pre_cand = recent_ff & s0_item_ff.precharge_allowed_mask;
   assign do_pre   = closed_now && !issued && pick.found;

   apps_pre_pick #(
      .SCAN_COUNT (NumScan)
   ) u_pre_pick (
      .cand (pre_cand),
      .pick (pick)
   );

   // next state and result
   always_comb begin
      drain_flag_in    = drain_flag_ff;
      policy_count_in  = policy_count_ff;
      policy_closed_in = policy_closed_ff;
      row_known_in     = row_known_ff;
      recent_in        = recent_ff;
      rsp_item_in      = rsp_item_ff;
      if (advance) begin
         drain_flag_in    = drain_now;
         policy_count_in  = count_now;
         policy_closed_in = closed_now;
         recent_in        = recent_mid;
         if (do_pre) recent_in[pick.bank] = 1'b0;
         if (row_we) row_known_in[sel_bank] = 1'b1;
         rsp_item_in                 = '0;
         rsp_item_in.issue_request   = issued;
         rsp_item_in.issue_is_write  = issued && drain_now;
         rsp_item_in.issue_precharge = do_pre;
         rsp_item_in.precharge_bank  = do_pre ? pick.bank : '0;
         rsp_item_in.closed_mode     = closed_now;
         rsp_item_in.draining        = drain_now;
         rsp_item_in.policy_count    = count_now;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         drain_high_ff    <= DRAIN_HIGH_RESET;
         drain_low_ff     <= DRAIN_LOW_RESET;
         closed_thresh_ff <= CLOSED_THRESH_RESET;
         open_thresh_ff   <= OPEN_THRESH_RESET;
         s0_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         drain_flag_ff    <= 1'b0;
         policy_count_ff  <= COUNT_RESET;
         policy_closed_ff <= 1'b0;
         row_known_ff     <= '0;
         recent_ff        <= '0;
      end else begin
         drain_high_ff    <= drain_high_in;
         drain_low_ff     <= drain_low_in;
         closed_thresh_ff <= closed_thresh_in;
         open_thresh_ff   <= open_thresh_in;
         s0_valid_ff      <= s0_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         drain_flag_ff    <= drain_flag_in;
         policy_count_ff  <= policy_count_in;
         policy_closed_ff <= policy_closed_in;
         row_known_ff     <= row_known_in;
         recent_ff        <= recent_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s0_item_ff  <= s0_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   // last row per bank, valid only where the known bit is set
   always_ff @(posedge clock) begin
      if (advance && row_we) begin
         last_row_ff[sel_bank] <= sel_row;
      end
   end

endmodule

`default_nettype wire

// ----- design/apps_checker.sv -----
// port-level checks of the scheduler and their binding
`default_nettype none

module apps_checker
   import apps_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   rsp_item_type rsp_item;
   assign rsp_item = rsp_item_type'(rsp_tdata);

   // a preemptive precharge only fills an idle closed-page cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_item.issue_precharge |->
         !rsp_item.issue_request && rsp_item.closed_mode)
      else $error("precharge issued outside an idle closed-page cycle");

   // a write issues only while draining
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_item.issue_is_write |->
         rsp_item.issue_request && rsp_item.draining)
      else $error("write issued without drain mode");

   // no precharge bank is reported without a precharge
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_item.issue_precharge |-> rsp_item.precharge_bank == '0)
      else $error("precharge bank set without a precharge");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

endmodule

bind adaptive_page_policy_scheduler apps_checker u_apps_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ----- tb/sv/adaptive_page_policy_scheduler_tb.sv -----
// self-checking testbench of the adaptive page policy scheduler with its own decision predictor
`default_nettype none

module adaptive_page_policy_scheduler_tb;
   import apps_pkg::*;

   localparam int TB_RANK_COUNT = 2;
   localparam int TB_BANK_COUNT = 8;
   localparam int ROW_BITS_TB   = 16;
   localparam int BANK_SPAN     = (TB_RANK_COUNT * TB_BANK_COUNT > NUM_BANK_IDX) ?
                                  NUM_BANK_IDX : TB_RANK_COUNT * TB_BANK_COUNT;
   localparam logic [15:0] ROW_MASK = 16'hFFFF >> (16 - ROW_BITS_TB);
   localparam int PHASE_ITEMS = 165;
   localparam int LONG_HOLD_AT = 300;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   csr_index_type         csr_index = CSR_DRAIN_HIGH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // predictor copy of the scheduler state and registers
   logic                drain_on;
   logic [COUNT_W-1:0]  page_count;
   logic                page_closed;
   logic [15:0]         row_seen [NUM_BANK_IDX];
   logic                row_known [NUM_BANK_IDX];
   logic                recent_col [NUM_BANK_IDX];
   logic [OCC_W-1:0]    cfg_drain_high;
   logic [OCC_W-1:0]    cfg_drain_low;
   logic [THRESH_W-1:0] cfg_closed_thresh;
   logic [THRESH_W-1:0] cfg_open_thresh;

   req_item_type pending_reqs[$];
   rsp_item_type expected_decisions[$];
   int items_queued   = 0;
   int items_accepted = 0;
   int results_seen   = 0;
   int mismatches     = 0;
   int send_gap       = 0;
   int recv_gap       = 0;
   logic long_hold_done = 1'b0;
   logic calm = 1'b0;

   adaptive_page_policy_scheduler #(
      .RANKS    (TB_RANK_COUNT),
      .BANKS    (TB_BANK_COUNT),
      .ROW_BITS (ROW_BITS_TB)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // row tracking and policy counter update for one issued request
   function automatic void note_access(cmd_op_type op, logic [3:0] bank, logic [15:0] row);
      logic hit;
      row = row & ROW_MASK;
      hit = row_known[bank] && (row_seen[bank] == row);
      if (page_closed) begin
         if (op == OP_COLUMN) begin
            if (hit) begin
               if (page_count != 0) page_count = page_count - 1'b1;
            end else begin
               row_seen[bank]  = row;
               row_known[bank] = 1'b1;
            end
            recent_col[bank] = 1'b1;
         end else if (op == OP_ACTIVATE || op == OP_PRECHARGE) begin
            recent_col[bank] = 1'b0;
         end
      end else if (op == OP_COLUMN && !hit) begin
         if (page_count != COUNT_TOP) page_count = page_count + 1'b1;
         row_seen[bank]  = row;
         row_known[bank] = 1'b1;
      end
   endfunction

   // one scheduling cycle: drain hysteresis, policy choice, issue, preemptive precharge
   function automatic rsp_item_type schedule_cycle(req_item_type it);
      rsp_item_type d;
      logic searching;
      d = '0;
      drain_on = drain_on && (it.writes_waiting > cfg_drain_low);
      if (it.writes_waiting > cfg_drain_high || it.reads_waiting == 0) drain_on = 1'b1;
      if (page_count > cfg_closed_thresh) page_closed = 1'b1;
      if (page_count < cfg_open_thresh) page_closed = 1'b0;
      if (drain_on) begin
         if (it.write_ready) begin
            note_access(it.write_next_op, it.write_bank_index, it.write_row);
            d.issue_request  = 1'b1;
            d.issue_is_write = 1'b1;
         end
      end else if (it.read_ready) begin
         note_access(it.read_next_op, it.read_bank_index, it.read_row);
         d.issue_request = 1'b1;
      end
      searching = page_closed && !d.issue_request;
      for (int b = 0; b < BANK_SPAN; b++) begin
         if (searching && recent_col[b] && it.precharge_allowed_mask[b]) begin
            recent_col[b]     = 1'b0;
            d.issue_precharge = 1'b1;
            d.precharge_bank  = b[BANK_W-1:0];
            searching         = 1'b0;
         end
      end
      d.closed_mode  = page_closed;
      d.draining     = drain_on;
      d.policy_count = page_count;
      return d;
   endfunction

   function automatic req_item_type pack_req(int wq, int rq, logic w_rdy, cmd_op_type w_op,
                                             int w_bank, int w_row, logic r_rdy,
                                             cmd_op_type r_op, int r_bank, int r_row,
                                             int mask);
      req_item_type it;
      it = '0;
      it.writes_waiting         = wq[OCC_W-1:0];
      it.reads_waiting          = rq[OCC_W-1:0];
      it.write_ready            = w_rdy;
      it.write_next_op          = w_op;
      it.write_bank_index       = w_bank[BANK_W-1:0];
      it.write_row              = w_row[15:0];
      it.read_ready             = r_rdy;
      it.read_next_op           = r_op;
      it.read_bank_index        = r_bank[BANK_W-1:0];
      it.read_row               = r_row[15:0];
      it.precharge_allowed_mask = mask[15:0];
      return it;
   endfunction

   function automatic cmd_op_type random_op();
      case ($urandom_range(0, 5))
         0, 1, 2: return OP_COLUMN;
         3:       return OP_ACTIVATE;
         4:       return OP_PRECHARGE;
         default: return OP_OTHER;
      endcase
   endfunction

   // bank and row mostly from a small pool so rows hit and banks turn recent
   function automatic int random_bank();
      return ($urandom_range(0, 3) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 15);
   endfunction

   function automatic int random_row();
      return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, 65535);
   endfunction

   function automatic req_item_type random_request();
      int wq, rq, mask, pick;
      pick = $urandom_range(0, 9);
      wq = (pick < 7) ? $urandom_range(0, 64) : (pick < 9) ? $urandom_range(65, 127) : 0;
      pick = $urandom_range(0, 9);
      rq = (pick == 0) ? 0 : (pick < 9) ? $urandom_range(1, 64) : $urandom_range(65, 127);
      case ($urandom_range(0, 3))
         0, 1:    mask = $urandom_range(0, 65535);
         2:       mask = 16'hFFFF;
         default: mask = ($urandom_range(0, 1) != 0) ? (1 << $urandom_range(0, 15)) : 0;
      endcase
      return pack_req(wq, rq, $urandom_range(0, 9) < 8, random_op(), random_bank(),
                      random_row(), $urandom_range(0, 9) < 8, random_op(), random_bank(),
                      random_row(), mask);
   endfunction

   task automatic queue_request(req_item_type it);
      pending_reqs.push_back(it);
      items_queued++;
   endtask

   // register write, mirrored into the predictor
   task automatic write_register(csr_index_type idx, int value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_DRAIN_HIGH:    cfg_drain_high    = value[OCC_W-1:0];
         CSR_DRAIN_LOW:     cfg_drain_low     = value[OCC_W-1:0];
         CSR_CLOSED_THRESH: cfg_closed_thresh = value[THRESH_W-1:0];
         default:           cfg_open_thresh   = value[THRESH_W-1:0];
      endcase
   endtask

   // wait until every queued request has been taken and every decision has come back
   task automatic settle_block();
      int n;
      for (n = 0; n < 20000 && (items_accepted != items_queued ||
                                expected_decisions.size() != 0); n++)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         send_gap   = 0;
      end else begin
         // transfer on the request side: predict its decision
         if (req_tvalid && req_tready) begin
            expected_decisions.push_back(schedule_cycle(req_tdata));
            items_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(0, 11) == 0) begin
               send_gap = $urandom_range(0, 18);
               req_tvalid <= 1'b0;
            end else begin
               req_tdata  <= pending_reqs.pop_front();
               req_tvalid <= 1'b1;
            end
         end
      end
   end

   // decision monitor and receiver stalls
   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap   = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            results_seen++;
            if (expected_decisions.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: no decision expected, got %h", results_seen, got);
            end else begin
               want = expected_decisions.pop_front();
               if (got.issue_request   !== want.issue_request   ||
                   got.issue_is_write  !== want.issue_is_write  ||
                   got.issue_precharge !== want.issue_precharge ||
                   got.precharge_bank  !== want.precharge_bank  ||
                   got.closed_mode     !== want.closed_mode     ||
                   got.draining        !== want.draining        ||
                   got.policy_count    !== want.policy_count) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $write("result %0d: expected issue=%0b wr=%0b pre=%0b bank=%0d",
                            results_seen, want.issue_request, want.issue_is_write,
                            want.issue_precharge, want.precharge_bank);
                     $display(" closed=%0b drain=%0b count=%0d",
                              want.closed_mode, want.draining, want.policy_count);
                     $write("result %0d: actual   issue=%0b wr=%0b pre=%0b bank=%0d",
                            results_seen, got.issue_request, got.issue_is_write,
                            got.issue_precharge, got.precharge_bank);
                     $display(" closed=%0b drain=%0b count=%0d",
                              got.closed_mode, got.draining, got.policy_count);
                  end
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else if (results_seen == LONG_HOLD_AT && !long_hold_done) begin
            // long hold-off so the block fills and back-pressures requests
            long_hold_done = 1'b1;
            recv_gap = 149;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            recv_gap = $urandom_range(0, 18);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // stimulus and end of run
   initial begin
      int phase, k;
      int high_marks [4] = '{40, 0, 64, 30};
      int low_marks [4]  = '{20, 0, 64, 10};
      int closed_ths [4] = '{11, 0, 15, 3};
      int open_ths [4]   = '{6, 0, 15, 12};
      drain_on          = 1'b0;
      page_count        = COUNT_RESET;
      page_closed       = 1'b0;
      cfg_drain_high    = DRAIN_HIGH_RESET;
      cfg_drain_low     = DRAIN_LOW_RESET;
      cfg_closed_thresh = CLOSED_THRESH_RESET;
      cfg_open_thresh   = OPEN_THRESH_RESET;
      for (k = 0; k < NUM_BANK_IDX; k++) begin
         row_seen[k]   = '0;
         row_known[k]  = 1'b0;
         recent_col[k] = 1'b0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: drain triggers, misses up to closed policy, hits, every op, precharge picks
      queue_request(pack_req(0, 0, 1, OP_COLUMN, 0, 0, 0, OP_COLUMN, 0, 0, 0));
      queue_request(pack_req(127, 127, 1, OP_COLUMN, 15, 16'hFFFF, 1, OP_COLUMN, 0, 0,
                             16'hFFFF));
      queue_request(pack_req(0, 5, 0, OP_OTHER, 0, 0, 1, OP_COLUMN, 1, 1, 0));
      queue_request(pack_req(0, 5, 0, OP_OTHER, 0, 0, 1, OP_COLUMN, 1, 2, 0));
      queue_request(pack_req(0, 5, 0, OP_OTHER, 0, 0, 1, OP_COLUMN, 1, 2, 0));
      queue_request(pack_req(0, 5, 0, OP_OTHER, 0, 0, 0, OP_COLUMN, 0, 0, 0));
      queue_request(pack_req(0, 5, 0, OP_OTHER, 0, 0, 0, OP_COLUMN, 0, 0, 16'hFFFF));
      queue_request(pack_req(0, 5, 0, OP_OTHER, 0, 0, 1, OP_COLUMN, 14, 5, 0));
      queue_request(pack_req(0, 5, 0, OP_OTHER, 0, 0, 1, OP_ACTIVATE, 14, 5, 0));
      queue_request(pack_req(0, 5, 0, OP_OTHER, 0, 0, 1, OP_COLUMN, 3, 7, 0));
      queue_request(pack_req(0, 5, 0, OP_OTHER, 0, 0, 1, OP_PRECHARGE, 3, 7, 0));
      queue_request(pack_req(0, 5, 0, OP_OTHER, 0, 0, 1, OP_OTHER, 3, 9, 0));
      queue_request(pack_req(0, 5, 0, OP_OTHER, 0, 0, 1, OP_COLUMN, 15, 16'hAAAA, 0));
      queue_request(pack_req(100, 9, 0, OP_COLUMN, 2, 0, 1, OP_COLUMN, 2, 0, 16'h7FFF));
      queue_request(pack_req(64, 9, 1, OP_ACTIVATE, 4, 16'h5555, 1, OP_COLUMN, 2, 0, 0));
      queue_request(pack_req(64, 9, 1, OP_PRECHARGE, 4, 0, 1, OP_COLUMN, 2, 0, 0));
      queue_request(pack_req(21, 1, 1, OP_OTHER, 4, 0, 1, OP_COLUMN, 2, 0, 0));
      queue_request(pack_req(20, 1, 1, OP_COLUMN, 4, 0, 0, OP_COLUMN, 2, 0, 16'h8000));
      for (k = 0; k < 7; k++)
         queue_request(pack_req(3, 40, 0, OP_COLUMN, 0, 0, 1, OP_COLUMN, 1, 2, 0));
      settle_block();

      // register settings, the last one random and without idling
      for (phase = 0; phase < 5; phase++) begin
         if (phase < 4) begin
            write_register(CSR_DRAIN_HIGH, high_marks[phase]);
            write_register(CSR_DRAIN_LOW, low_marks[phase]);
            write_register(CSR_CLOSED_THRESH, closed_ths[phase]);
            write_register(CSR_OPEN_THRESH, open_ths[phase]);
         end else begin
            write_register(CSR_DRAIN_HIGH, $urandom_range(0, 64));
            write_register(CSR_DRAIN_LOW, $urandom_range(0, 64));
            write_register(CSR_CLOSED_THRESH, $urandom_range(0, 15));
            write_register(CSR_OPEN_THRESH, $urandom_range(0, 15));
            calm = 1'b1;
         end
         for (k = 0; k < PHASE_ITEMS; k++)
            queue_request(random_request());
         settle_block();
      end

      if (mismatches == 0 && expected_decisions.size() == 0 &&
          items_accepted == items_queued) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // run limit
   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire
